// ===== rtl/core/ile_pkg.sv =====
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types for the indexed list engine: operation and status codes and
// the control word that the row hands to every storage cell.
// ----------------------------------------------------------------------------
`default_nettype none

package ile_pkg;

  typedef enum logic [2:0] {
    OP_APPEND = 3'd0,
    OP_READ   = 3'd1,
    OP_WRITE  = 3'd2,
    OP_POP    = 3'd3,
    OP_SWAP   = 3'd4,
    OP_DELETE = 3'd5
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // wr: cell at wr_pos loads wdata; shift: cells in [lo, hi) take the right neighbor
  typedef struct packed {
    logic wr;
    logic shift;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== rtl/core/ile_cell.sv =====
// ----------------------------------------------------------------------------
// ile_cell
// One storage cell of the list: holds a single 64-bit entry, loads a new word
// when addressed, or takes its right neighbor's entry during a delete shift.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_cell
  import ile_pkg::*;
#(
  parameter int unsigned AW  = 8,
  parameter int unsigned POS = 0
) (
  input  wire logic            clk_i,
  input  wire cell_ctl_t       ctl_i,
  input  wire logic [AW-1:0]   wr_pos_i,
  input  wire logic [AW-1:0]   lo_i,
  input  wire logic [AW-1:0]   hi_i,
  input  wire logic [63:0]     wdata_i,
  input  wire logic [63:0]     next_i,
  output logic      [63:0]     entry_o
);

  localparam logic [AW-1:0] MyPos = AW'(POS);

  logic [63:0] entry_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr && (wr_pos_i == MyPos)) begin
      entry_q <= wdata_i;
    end else if (ctl_i.shift && (MyPos >= lo_i) && (MyPos < hi_i)) begin
      entry_q <= next_i;
    end
  end

  assign entry_o = entry_q;

endmodule

`default_nettype wire

// ===== rtl/core/ile_row.sv =====
// ----------------------------------------------------------------------------
// ile_row
// Row of DEPTH storage cells chained left to right, with a registered
// read port that selects one cell per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_row
  import ile_pkg::*;
#(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = 8
) (
  input  wire logic            clk_i,
  input  wire cell_ctl_t       ctl_i,
  input  wire logic [AW-1:0]   wr_pos_i,
  input  wire logic [AW-1:0]   lo_i,
  input  wire logic [AW-1:0]   hi_i,
  input  wire logic [63:0]     wdata_i,
  input  wire logic [AW-1:0]   rd_addr_i,
  output logic      [63:0]     rdata_o
);

  logic [63:0] entry_w [DEPTH];
  logic [63:0] rdata_q;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    logic [63:0] next_w;
    if (k == DEPTH - 1) begin : g_end
      assign next_w = '0;
    end else begin : g_mid
      assign next_w = entry_w[k+1];
    end

    ile_cell #(
      .AW  (AW),
      .POS (k)
    ) u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl_i),
      .wr_pos_i (wr_pos_i),
      .lo_i     (lo_i),
      .hi_i     (hi_i),
      .wdata_i  (wdata_i),
      .next_i   (next_w),
      .entry_o  (entry_w[k])
    );
  end

  // read sees the contents before any write or shift on the same edge
  always_ff @(posedge clk_i) begin
    rdata_q <= entry_w[rd_addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/indexed_list_engine.sv =====
// ----------------------------------------------------------------------------
// indexed_list_engine
// Bounded list of 64-bit words: append, read, write, pop, swap-remove and
// ordered delete, held in a chain of storage cells.
//
//   channel   | handshake            | payload
//   ----------+----------------------+-------------------------------------
//   request   | start / busy         | operation_i, index_i, value_i
//   result    | done_o (1-cycle)     | data_o, status_o, count_o
//
// Append, read, write, pop and delete pass S_EXEC, which updates the cells and
// reads the addressed cell, then S_RESP, which shows the result while the next
// request is taken. Swap-remove passes S_EXEC, S_SW_LAST, S_SW_FILL and S_RESP:
// the single cell read port is used twice (removed entry, then last entry)
// before the refill. Delete shifts all later cells one place at once.
// Reset clears the length and control only; cell contents are undefined.
// The result is shown for one cycle and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_list_engine
  import ile_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [2:0]                    operation_i,
  input  wire logic [7:0]                    index_i,
  input  wire logic [63:0]                   value_i,
  output logic                               done_o,
  output logic [63:0]                        data_o,
  output logic [1:0]                         status_o,
  output logic [$clog2(DEPTH+1)-1:0]         count_o
);

  localparam int unsigned AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned XW0 = (CW > 8) ? CW : 8;
  localparam int unsigned XW  = (XW0 > AW) ? XW0 : AW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SW_LAST,
    S_SW_FILL,
    S_RESP
  } state_e;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_RD,
    SRC_HOLD
  } src_e;

  state_e        state_q;
  src_e          src_q;
  status_e       status_q;
  logic [CW-1:0] len_q;

  op_e           op_q;
  logic [7:0]    idx_q;
  logic [63:0]   val_q;
  logic [63:0]   hold_q;

  logic          accept;
  logic [XW-1:0] idx_x;
  logic [AW-1:0] idx_a;
  logic [AW-1:0] len_a;
  logic [CW-1:0] len_m1;
  logic [AW-1:0] len_m1_a;
  logic          in_range;
  logic          full;
  logic          empty;

  cell_ctl_t     ctl;
  logic [AW-1:0] wr_pos;
  logic [63:0]   wdata;
  logic [AW-1:0] rd_addr;
  logic [63:0]   rdata;

  assign busy   = (state_q != S_IDLE) && (state_q != S_RESP);
  assign accept = start && !busy;

  assign idx_x    = XW'(idx_q);
  assign idx_a    = idx_x[AW-1:0];
  assign len_a    = len_q[AW-1:0];
  assign len_m1   = len_q - CW'(1);
  assign len_m1_a = len_m1[AW-1:0];
  assign in_range = idx_x < XW'(len_q);
  assign full     = len_q == CW'(DEPTH);
  assign empty    = len_q == '0;

  // cell control and read address
  always_comb begin
    ctl     = '0;
    wr_pos  = idx_a;
    wdata   = val_q;
    rd_addr = idx_a;
    unique case (state_q)
      S_EXEC: begin
        if (op_q == OP_POP) begin
          rd_addr = len_m1_a;
        end
        if (op_q == OP_APPEND) begin
          ctl.wr = !full;
          wr_pos = len_a;
        end else if (op_q == OP_WRITE) begin
          ctl.wr = in_range;
        end else if (op_q == OP_DELETE) begin
          ctl.shift = in_range;
        end
      end
      S_SW_LAST: begin
        rd_addr = len_m1_a;
      end
      S_SW_FILL: begin
        ctl.wr = 1'b1;
        wdata  = rdata;
      end
      default: begin
      end
    endcase
  end

  ile_row #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_row (
    .clk_i     (clk_i),
    .ctl_i     (ctl),
    .wr_pos_i  (wr_pos),
    .lo_i      (idx_a),
    .hi_i      (len_m1_a),
    .wdata_i   (wdata),
    .rd_addr_i (rd_addr),
    .rdata_o   (rdata)
  );

  // request and swap payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(operation_i);
      idx_q <= index_i;
      val_q <= value_i;
    end
    if (state_q == S_SW_LAST) begin
      hold_q <= rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      src_q    <= SRC_ZERO;
      status_q <= ST_OK;
      len_q    <= '0;
    end else begin
      unique case (state_q)
        S_IDLE, S_RESP: begin
          state_q <= accept ? S_EXEC : S_IDLE;
        end
        S_EXEC: begin
          state_q  <= S_RESP;
          src_q    <= SRC_ZERO;
          status_q <= ST_OK;
          unique case (op_q)
            OP_APPEND: begin
              if (full) begin
                status_q <= ST_FULL;
              end else begin
                len_q <= len_q + CW'(1);
              end
            end
            OP_READ: begin
              if (in_range) begin
                src_q <= SRC_RD;
              end else begin
                status_q <= ST_RANGE;
              end
            end
            OP_WRITE: begin
              if (!in_range) begin
                status_q <= ST_RANGE;
              end
            end
            OP_POP: begin
              if (empty) begin
                status_q <= ST_RANGE;
              end else begin
                src_q <= SRC_RD;
                len_q <= len_m1;
              end
            end
            OP_SWAP: begin
              if (in_range) begin
                state_q <= S_SW_LAST;
              end else begin
                status_q <= ST_RANGE;
              end
            end
            OP_DELETE: begin
              if (in_range) begin
                src_q <= SRC_RD;
                len_q <= len_m1;
              end else begin
                status_q <= ST_RANGE;
              end
            end
            default: begin
            end
          endcase
        end
        S_SW_LAST: begin
          state_q <= S_SW_FILL;
        end
        S_SW_FILL: begin
          state_q  <= S_RESP;
          src_q    <= SRC_HOLD;
          status_q <= ST_OK;
          len_q    <= len_m1;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o   = state_q == S_RESP;
  assign status_o = status_q;
  assign count_o  = len_q;

  always_comb begin
    unique case (src_q)
      SRC_RD:   data_o = rdata;
      SRC_HOLD: data_o = hold_q;
      default:  data_o = '0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/ile_checker.sv =====
// ----------------------------------------------------------------------------
// ile_checker
// Port-level checks for the indexed list engine, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ile_checker
  import ile_pkg::*;
#(
  parameter int unsigned DEPTH = 256
) (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      start,
  input wire logic                      busy,
  input wire logic                      done_o,
  input wire logic [63:0]               data_o,
  input wire logic [1:0]                status_o,
  input wire logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned CW = $clog2(DEPTH + 1);

  // a taken request keeps the engine occupied on the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("engine not busy after a transaction was taken");

  // length moves only together with a result
  a_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !done_o |-> $stable(count_o))
    else $error("count changed without a result");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o != ST_OK) |-> data_o == '0)
    else $error("nonzero data on an error result");

  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (status_o == ST_FULL) |-> count_o == CW'(DEPTH))
    else $error("full status while list not full");

endmodule

bind indexed_list_engine ile_checker #(
  .DEPTH (DEPTH)
) u_ile_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .data_o   (data_o),
  .status_o (status_o),
  .count_o  (count_o)
);

`default_nettype wire
